@@ sv/esc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Types, codes and constants shared by the epoch-to-calendar modules.
// ----------------------------------------------------------------------------
package esc_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_WRITE
    } esc_state_t;

    typedef enum logic [2:0] {
        UNIT_YEAR,
        UNIT_MONTH,
        UNIT_DAY,
        UNIT_HOUR,
        UNIT_MIN
    } esc_unit_t;

    typedef struct packed {
        logic      load;
        logic      walk;
        esc_unit_t unit;
        logic      out_load;
    } esc_cmd_t;

    typedef struct packed {
        logic fit;
    } esc_status_t;

    localparam int unsigned OUT_W  = 48;
    localparam int unsigned STEP_W = 25;

    localparam logic [STEP_W-1:0] SECS_PER_MIN     = 25'd60;
    localparam logic [STEP_W-1:0] SECS_PER_HOUR    = 25'd3600;
    localparam logic [STEP_W-1:0] SECS_PER_DAY     = 25'd86400;
    localparam logic [STEP_W-1:0] SECS_COMMON_YEAR = 25'd31536000;
    localparam logic [STEP_W-1:0] SECS_LEAP_YEAR   = 25'd31622400;

    localparam logic [7:0] EPOCH_YEAR_1900 = 8'd70;
    localparam logic [1:0] EPOCH_MOD4      = 2'd2;
    localparam logic [6:0] EPOCH_MOD100    = 7'd70;
    localparam logic [8:0] EPOCH_MOD400    = 9'd370;

    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd11;

    localparam logic [4:0] DAYS_MONTH_MIN = 5'd28;

    localparam logic [2:0] EPOCH_WEEKDAY = 3'd4;
    localparam logic [3:0] DAYS_PER_WEEK = 4'd7;

    function automatic logic [4:0] month_days(input logic [3:0] mon);
        logic [4:0] len;
        case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [STEP_W-1:0] month_seconds(input logic [4:0] days);
        logic [STEP_W-1:0] secs;
        case (days)
            5'd28:   secs = 25'd2419200;
            5'd29:   secs = 25'd2505600;
            5'd30:   secs = 25'd2592000;
            default: secs = 25'd2678400;
        endcase
        return secs;
    endfunction

endpackage

@@ sv/epoch_seconds_to_calendar.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts unsigned seconds since 1970-01-01 UTC to broken-down UTC time.
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_*      in   tdata: epoch_seconds (low SECONDS_WIDTH bits used)
// m_*      out  tdata: second, minute, hour, mday, month, year-1900, yday, wday
//
// One transaction at a time, by repeated subtraction: the sequencer walks
// the elapsed years, months, days, hours and minutes in that order, then
// writes the result. A wider SECONDS_WIDTH lengthens the year walk.
// s_tready is high only while idle. A finished result sits in the output
// register; the next transaction runs while it waits and stalls at the write
// step until m_tready frees the register.
// Reset clears the sequencer and output valid; no datapath reset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar #(
    parameter int unsigned SECONDS_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [SECONDS_WIDTH-1:0] epoch_seconds, zero padded to bytes
    input  logic [((SECONDS_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
    // [21:17] day_of_month, [25:22] month_index, [33:26] year_since_1900,
    // [42:34] day_of_year, [45:43] weekday, [47:46] zero
    output logic [esc_pkg::OUT_W-1:0]         m_tdata
);
    import esc_pkg::*;

    esc_cmd_t    cmd;
    esc_status_t status;

    esc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    esc_dp #(
        .SECONDS_WIDTH (SECONDS_WIDTH)
    ) u_dp (
        .clk     (clk),
        .seconds (s_tdata[SECONDS_WIDTH-1:0]),
        .cmd     (cmd),
        .status  (status),
        .result  (m_tdata)
    );

endmodule

@@ sv/esc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer: year, month, day, hour and minute walks, output hand-off.
// ----------------------------------------------------------------------------
module esc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  esc_pkg::esc_status_t status,
    output esc_pkg::esc_cmd_t    cmd
);
    import esc_pkg::*;

    esc_state_t   state_reg, state_next;
    logic         out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (status.fit)
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (status.fit)
                begin
                    state_next = ST_DAY;
                end
            end
            ST_DAY:
            begin
                if (status.fit)
                begin
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR:
            begin
                if (status.fit)
                begin
                    state_next = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (status.fit)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_YEAR:
            begin
                cmd.walk = 1'b1;
                cmd.unit = UNIT_YEAR;
            end
            ST_MONTH:
            begin
                cmd.walk = 1'b1;
                cmd.unit = UNIT_MONTH;
            end
            ST_DAY:
            begin
                cmd.walk = 1'b1;
                cmd.unit = UNIT_DAY;
            end
            ST_HOUR:
            begin
                cmd.walk = 1'b1;
                cmd.unit = UNIT_HOUR;
            end
            ST_MIN:
            begin
                cmd.walk = 1'b1;
                cmd.unit = UNIT_MIN;
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

@@ sv/esc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_dp
// Datapath: repeated-subtraction walk over years, months, days, hours and
// minutes, leap-year counters, weekday tracking and output register.
// ----------------------------------------------------------------------------
module esc_dp #(
    parameter int unsigned SECONDS_WIDTH = 32
) (
    input  logic                        clk,
    input  logic [SECONDS_WIDTH-1:0]    seconds,
    input  esc_pkg::esc_cmd_t           cmd,
    output esc_pkg::esc_status_t        status,
    output logic [esc_pkg::OUT_W-1:0]   result
);
    import esc_pkg::*;

    localparam int unsigned W = SECONDS_WIDTH;

    logic [W-1:0] rem_reg, rem_next;
    logic [7:0]   yr_reg, yr_next;
    logic [1:0]   m4_reg, m4_next;
    logic [6:0]   m100_reg, m100_next;
    logic [8:0]   m400_reg, m400_next;
    logic [3:0]   mon_reg, mon_next;
    logic [4:0]   mday_reg, mday_next;
    logic [8:0]   yday_reg, yday_next;
    logic [4:0]   hour_reg, hour_next;
    logic [5:0]   min_reg, min_next;
    logic [2:0]   wk_reg, wk_next;
    logic [OUT_W-1:0] out_reg, out_next;

    logic              leap;
    logic [4:0]        mdays;
    logic [STEP_W-1:0] step_len;
    logic [1:0]        wk_delta;
    logic [3:0]        wk_sum;
    logic [2:0]        wk_wrap;
    logic              fit;

    assign leap  = (m4_reg == 2'd0) && ((m100_reg != 7'd0) || (m400_reg == 9'd0));
    assign mdays = month_days(mon_reg) + {4'd0, (leap && (mon_reg == MONTH_FEB))};

    // length of one step in seconds and its weekday advance
    always_comb
    begin
        unique case (cmd.unit)
            UNIT_YEAR:
            begin
                step_len = leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
                wk_delta = leap ? 2'd2 : 2'd1;
            end
            UNIT_MONTH:
            begin
                step_len = month_seconds(mdays);
                wk_delta = 2'(mdays - DAYS_MONTH_MIN);
            end
            UNIT_DAY:
            begin
                step_len = SECS_PER_DAY;
                wk_delta = 2'd1;
            end
            UNIT_HOUR:
            begin
                step_len = SECS_PER_HOUR;
                wk_delta = 2'd0;
            end
            default:
            begin
                step_len = SECS_PER_MIN;
                wk_delta = 2'd0;
            end
        endcase
    end

    // December never steps: the year length bounds the remainder
    assign fit        = ((cmd.unit == UNIT_MONTH) && (mon_reg == MONTH_DEC)) ||
                        (rem_reg < W'(step_len));
    assign status.fit = fit;

    assign wk_sum  = {1'b0, wk_reg} + {2'b00, wk_delta};
    assign wk_wrap = (wk_sum >= DAYS_PER_WEEK) ? 3'(wk_sum - DAYS_PER_WEEK) : wk_sum[2:0];

    always_comb
    begin
        rem_next  = rem_reg;
        yr_next   = yr_reg;
        m4_next   = m4_reg;
        m100_next = m100_reg;
        m400_next = m400_reg;
        mon_next  = mon_reg;
        mday_next = mday_reg;
        yday_next = yday_reg;
        hour_next = hour_reg;
        min_next  = min_reg;
        wk_next   = wk_reg;
        out_next  = out_reg;

        if (cmd.load)
        begin
            rem_next  = seconds;
            yr_next   = EPOCH_YEAR_1900;
            m4_next   = EPOCH_MOD4;
            m100_next = EPOCH_MOD100;
            m400_next = EPOCH_MOD400;
            mon_next  = '0;
            mday_next = 5'd1;
            yday_next = '0;
            hour_next = '0;
            min_next  = '0;
            wk_next   = EPOCH_WEEKDAY;
        end

        if (cmd.walk && !fit)
        begin
            rem_next = rem_reg - W'(step_len);
            wk_next  = wk_wrap;
            case (cmd.unit)
                UNIT_YEAR:
                begin
                    yr_next   = yr_reg + 8'd1;
                    m4_next   = m4_reg + 2'd1;
                    m100_next = (m100_reg == 7'd99)  ? 7'd0 : m100_reg + 7'd1;
                    m400_next = (m400_reg == 9'd399) ? 9'd0 : m400_reg + 9'd1;
                end
                UNIT_MONTH:
                begin
                    mon_next  = mon_reg + 4'd1;
                    yday_next = yday_reg + {4'd0, mdays};
                end
                UNIT_DAY:
                begin
                    mday_next = mday_reg + 5'd1;
                    yday_next = yday_reg + 9'd1;
                end
                UNIT_HOUR:
                begin
                    hour_next = hour_reg + 5'd1;
                end
                default:
                begin
                    min_next = min_reg + 6'd1;
                end
            endcase
        end

        if (cmd.out_load)
        begin
            out_next = {2'b00, wk_reg, yday_reg, yr_reg, mon_reg, mday_reg,
                        hour_reg, min_reg, rem_reg[5:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        yr_reg   <= yr_next;
        m4_reg   <= m4_next;
        m100_reg <= m100_next;
        m400_reg <= m400_next;
        mon_reg  <= mon_next;
        mday_reg <= mday_next;
        yday_reg <= yday_next;
        hour_reg <= hour_next;
        min_reg  <= min_next;
        wk_reg   <= wk_next;
        out_reg  <= out_next;
    end

    assign result = out_reg;

endmodule

@@ dv/calendar_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_checker
// Watches both stream channels of epoch_seconds_to_calendar. Each accepted
// input is converted to a UTC calendar date and queued; each accepted output
// is compared field by field with the oldest queued date.
// ----------------------------------------------------------------------------
module calendar_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    // [31:0] epoch_seconds
    input  logic [31:0]               s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    // [5:0] sec, [11:6] min, [16:12] hour, [21:17] mday, [25:22] month,
    // [33:26] year-1900, [42:34] yday, [45:43] wday, [47:46] zero
    input  logic [esc_pkg::OUT_W-1:0] m_tdata,
    output int                        errors,
    output int                        pending
);

    typedef struct packed {
        logic [1:0] pad;
        logic [2:0] wday;
        logic [8:0] yday;
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] mday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } calendar_t;

    typedef struct {
        logic [31:0] seconds;
        calendar_t   date;
    } queued_date_t;

    queued_date_t expected_dates[$];

    function automatic bit year_is_leap(input int unsigned year);
        return (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned month, input bit leap);
        if (month == 1)
            return leap ? 29 : 28;
        if (month == 3 || month == 5 || month == 8 || month == 10)
            return 30;
        return 31;
    endfunction

    function automatic calendar_t calendar_of(input logic [31:0] seconds);
        longint unsigned t;
        longint unsigned total_days;
        longint unsigned days;
        int unsigned     year;
        int unsigned     month;
        int unsigned     yday;
        int unsigned     mlen;
        bit              leap;
        calendar_t       c;
        c = '0;
        t = longint'(seconds);
        c.second = 6'(t % 60);
        t = t / 60;
        c.minute = 6'(t % 60);
        t = t / 60;
        c.hour = 5'(t % 24);
        total_days = t / 24;
        days = total_days;
        year = 1970;
        leap = year_is_leap(year);
        while (days >= (leap ? 366 : 365)) begin
            days = days - (leap ? 366 : 365);
            year++;
            leap = year_is_leap(year);
        end
        month = 0;
        yday = 0;
        mlen = days_in_month(month, leap);
        while (month < 11 && days >= mlen) begin
            days = days - mlen;
            yday = yday + mlen;
            month++;
            mlen = days_in_month(month, leap);
        end
        yday = yday + 32'(days);
        c.mday  = 5'(days + 1);
        c.month = 4'(month);
        c.year  = 8'(year - 1900);
        c.yday  = 9'(yday);
        c.wday  = 3'((total_days + 4) % 7);
        return c;
    endfunction

    task automatic report(input string what, input logic [31:0] seconds,
                          input longint unsigned exp_val, input longint unsigned got_val);
        errors++;
        $display("[%0t] mismatch %s for %0d s: expected %0d, got %0d",
                 $realtime, what, seconds, exp_val, got_val);
    endtask

    task automatic compare_date(input queued_date_t e, input calendar_t got);
        if (got.second != e.date.second)
            report("second", e.seconds, 64'(e.date.second), 64'(got.second));
        if (got.minute != e.date.minute)
            report("minute", e.seconds, 64'(e.date.minute), 64'(got.minute));
        if (got.hour != e.date.hour)
            report("hour", e.seconds, 64'(e.date.hour), 64'(got.hour));
        if (got.mday != e.date.mday)
            report("mday", e.seconds, 64'(e.date.mday), 64'(got.mday));
        if (got.month != e.date.month)
            report("month", e.seconds, 64'(e.date.month), 64'(got.month));
        if (got.year != e.date.year)
            report("year", e.seconds, 64'(e.date.year), 64'(got.year));
        if (got.yday != e.date.yday)
            report("yday", e.seconds, 64'(e.date.yday), 64'(got.yday));
        if (got.wday != e.date.wday)
            report("wday", e.seconds, 64'(e.date.wday), 64'(got.wday));
        if (got.pad != 2'b00)
            report("padding", e.seconds, 64'd0, 64'(got.pad));
    endtask

    always @(posedge clk) begin
        queued_date_t q;
        if (!rst_n) begin
            expected_dates.delete();
            errors = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                q.seconds = s_tdata;
                q.date    = calendar_of(s_tdata);
                expected_dates.push_back(q);
            end
            if (m_tvalid && m_tready) begin
                if (expected_dates.size() == 0) begin
                    report("unexpected transaction", 32'd0, 64'd0, 64'(m_tdata));
                end else begin
                    q = expected_dates.pop_front();
                    compare_date(q, calendar_t'(m_tdata));
                end
            end
        end
        pending = expected_dates.size();
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives epoch_seconds_to_calendar with directed corner times (field limits,
// leap days, century and 32-bit ends) and then random times, with random
// idling on both channels and one long output hold-off. calendar_checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int SECONDS_WIDTH  = 32;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int HOLD_CYCLES    = 800;
    localparam int HOLD_AT_ITEM   = 600;
    localparam int DRAIN_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [31:0]               s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [esc_pkg::OUT_W-1:0] m_tdata;

    int errors;
    int pending;
    int sent_count = 0;
    int idle_cycles = 0;
    bit held = 1'b0;
    bit quiet;

    logic [31:0] corner_times [22] = '{
        32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd31535999, 32'd31536000, 32'd68169600, 32'd94694399,
        32'd946684799, 32'd951782400, 32'd951868800, 32'd978307199,
        32'd2147483647, 32'd2147483648, 32'd4107456000, 32'd4107542400,
        32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF
    };

    assign quiet = (sent_count >= 200) && (sent_count < 450);

    initial begin
        forever #6 clk = ~clk;
    end

    epoch_seconds_to_calendar #(
        .SECONDS_WIDTH(SECONDS_WIDTH)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    calendar_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .errors  (errors),
        .pending (pending)
    );

    function automatic logic [31:0] random_time();
        longint unsigned day;
        int unsigned     kind;
        kind = $urandom_range(0, 9);
        if (kind < 5)
            return $urandom();
        if (kind < 8) begin
            day = $urandom_range(0, 49709);
            case ($urandom_range(0, 2))
                0:       return 32'(day * 86400);
                1:       return 32'(day * 86400 + 86399);
                default: return 32'(day * 86400 + $urandom_range(0, 86399));
            endcase
        end
        return $urandom_range(0, 200000000);
    endfunction

    task automatic send_time(input logic [31:0] seconds);
        while (!quiet && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= seconds;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_count++;
    endtask

    // receiver: random back-pressure, one long hold-off
    initial begin
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (!held && sent_count >= HOLD_AT_ITEM) begin
                held = 1'b1;
                m_tready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            m_tready <= quiet || ($urandom_range(0, 99) >= 13);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (corner_times[i])
            send_time(corner_times[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_time(random_time());
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
